### sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define SVCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the following cycle
`define SVCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/svcd_pkg.sv
// shared constants, type and lookup function of the servo command decoder
// no dependencies
`timescale 1ns / 1ps

package svcd_pkg;

   localparam int unsigned ByteW    = 8;
   localparam int unsigned AngleW   = 8;
   localparam int unsigned PulseW   = 12;
   localparam int unsigned PosW     = 3;

   localparam logic [ByteW-1:0]  CharLf     = 8'd10;
   localparam logic [ByteW-1:0]  CharCr     = 8'd13;
   localparam logic [ByteW-1:0]  CharZero   = 8'h30;
   localparam logic [ByteW-1:0]  CharNine   = 8'h39;
   localparam logic [PosW-1:0]   PrefixLen  = 3'd6;
   localparam logic [AngleW-1:0] AngleMax   = 8'd180;
   localparam logic [PulseW-1:0] PulseBase  = 12'd500;
   localparam logic [PulseW-1:0] PulseTop   = 12'd2500;

   // 1000/90 = 100/9 as a Q4.16 fixed-point reciprocal (20 bits, 16 fraction bits), exact for angle <= 180
   localparam int unsigned       ScaleShift = 16;
   localparam int unsigned       ScaleW     = 20;
   localparam logic [ScaleW-1:0] ScaleMul   = 20'd728178;
   localparam int unsigned       ProdW      = AngleW + ScaleW;

   // parser outcome for one byte
   typedef struct packed {
      logic              fire;
      logic [AngleW-1:0] angle_raw;
   } line_event_type;

   // expected character at each prefix position of "servo:"
   function automatic logic [ByteW-1:0] prefix_char(input logic [PosW-1:0] pos);
      logic [ByteW-1:0] ch;
      case (pos)
         3'd0:    ch = 8'h73;
         3'd1:    ch = 8'h65;
         3'd2:    ch = 8'h72;
         3'd3:    ch = 8'h76;
         3'd4:    ch = 8'h6f;
         3'd5:    ch = 8'h3a;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

### sv/svcd_if.sv
// request and response channel interfaces of the servo command decoder
// depends on svcd_pkg
`timescale 1ns / 1ps

interface svcd_req_if;
   logic                        valid;
   logic                        ready;
   logic [svcd_pkg::ByteW-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface svcd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [svcd_pkg::AngleW-1:0] angle;
   logic [svcd_pkg::PulseW-1:0] pulse_us;

   modport source (output valid, output angle, output pulse_us, input ready);
   modport sink   (input valid, input angle, input pulse_us, output ready);
endinterface

### sv/svcd_line_parser.sv
// line state of the command parser: prefix check, digit accumulation, line end
// depends on svcd_pkg
`timescale 1ns / 1ps

module svcd_line_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic [svcd_pkg::ByteW-1:0]     rx_byte,
   output svcd_pkg::line_event_type       line_event
);

   logic [svcd_pkg::PosW-1:0]   position_ff, position_in;
   logic                        match_ff, match_in;
   logic                        stopped_ff, stopped_in;
   logic [svcd_pkg::AngleW-1:0] acc_ff, acc_in;
   logic [svcd_pkg::AngleW-1:0] acc_times_ten;
   logic [svcd_pkg::AngleW-1:0] digit;

   // acc*10 modulo 256 as shift-add, plus the digit value
   assign acc_times_ten = {acc_ff[4:0], 3'b000} + {acc_ff[6:0], 1'b0};
   assign digit         = rx_byte - svcd_pkg::CharZero;

   // a result only at line feed after a full, matching prefix
   assign line_event.fire      = (rx_byte == svcd_pkg::CharLf)
                                 && (position_ff == svcd_pkg::PrefixLen) && match_ff;
   assign line_event.angle_raw = acc_ff;

   // next line state for the byte in hand
   always_comb begin
      position_in = position_ff;
      match_in    = match_ff;
      stopped_in  = stopped_ff;
      acc_in      = acc_ff;
      if (rx_byte == svcd_pkg::CharLf) begin
         position_in = '0;
         match_in    = 1'b1;
         stopped_in  = 1'b0;
         acc_in      = '0;
      end else if (position_ff != svcd_pkg::PrefixLen) begin
         if (rx_byte != svcd_pkg::prefix_char(position_ff)) begin
            match_in = 1'b0;
         end
         position_in = position_ff + 3'd1;
      end else if (!stopped_ff) begin
         if (rx_byte inside {[svcd_pkg::CharZero:svcd_pkg::CharNine]}) begin
            acc_in = acc_times_ten + digit;
         end else if (rx_byte == svcd_pkg::CharCr) begin
            stopped_in = 1'b1;
         end
      end
   end

   // state registers, cleared to an empty line
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         match_ff    <= 1'b1;
         stopped_ff  <= 1'b0;
         acc_ff      <= '0;
      end else if (advance) begin
         position_ff <= position_in;
         match_ff    <= match_in;
         stopped_ff  <= stopped_in;
         acc_ff      <= acc_in;
      end
   end

endmodule

### sv/svcd_pulse_map.sv
// clamp of the accumulated angle and its mapping to a pulse width
// depends on svcd_pkg
`timescale 1ns / 1ps

module svcd_pulse_map (
   input  logic [svcd_pkg::AngleW-1:0] angle_raw,
   output logic [svcd_pkg::AngleW-1:0] angle,
   output logic [svcd_pkg::PulseW-1:0] pulse_us
);

   logic [svcd_pkg::ProdW-1:0] product;

   // clamp to the servo range
   assign angle = (angle_raw > svcd_pkg::AngleMax) ? svcd_pkg::AngleMax : angle_raw;

   // angle*100/9 by reciprocal multiply, floor is exact over 0..180
   assign product  = {{svcd_pkg::ScaleW{1'b0}}, angle} * {{svcd_pkg::AngleW{1'b0}},
                     svcd_pkg::ScaleMul};
   assign pulse_us = svcd_pkg::PulseBase
                     + product[svcd_pkg::ScaleShift +: svcd_pkg::PulseW];

endmodule

### sv/servo_command_line_decoder_core.sv
// servo command line decoder: request register, line parser, response register
// depends on svcd_pkg, svcd_if, svcd_line_parser, svcd_pulse_map
`timescale 1ns / 1ps
//
//   channel   direction  payload            width
//   req_chan  in         rx_byte            8
//   rsp_chan  out        angle, pulse_us    8, 12
//
// one byte per cycle is taken while the response register can move on.
// a response is registered once the line feed request that ends its line leaves the request register.
// the parser state updates in the same cycle the byte leaves the request register.
// synchronous reset clears the valid bits of both registers and starts an empty line.
// a held response stalls the request register, and req ready drops while it holds a byte.

module servo_command_line_decoder_core (
   input  logic       clock,
   input  logic       reset,
   svcd_req_if.sink   req_chan,
   svcd_rsp_if.source rsp_chan
);

   logic                        in_valid_ff;
   logic [svcd_pkg::ByteW-1:0]  in_byte_ff;
   logic                        out_valid_ff;
   logic [svcd_pkg::AngleW-1:0] angle_ff;
   logic [svcd_pkg::PulseW-1:0] pulse_ff;
   logic                        advance;
   logic [svcd_pkg::AngleW-1:0] angle_in;
   logic [svcd_pkg::PulseW-1:0] pulse_in;
   svcd_pkg::line_event_type    line_event;

   // byte moves on when the response slot is free or being emptied
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   svcd_line_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .rx_byte    (in_byte_ff),
      .line_event (line_event)
   );

   svcd_pulse_map u_pulse (
      .angle_raw (line_event.angle_raw),
      .angle     (angle_in),
      .pulse_us  (pulse_in)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && line_event.fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && line_event.fire) begin
         angle_ff <= angle_in;
         pulse_ff <= pulse_in;
      end
   end

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.angle    = angle_ff;
   assign rsp_chan.pulse_us = pulse_ff;

endmodule

### sv/svcd_checker.sv
// port-level checks of the servo command decoder, bound to the top level
// depends on svcd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svcd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [svcd_pkg::ByteW-1:0]  req_rx_byte,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [svcd_pkg::AngleW-1:0] rsp_angle,
   input logic [svcd_pkg::PulseW-1:0] rsp_pulse_us
);

   // a held response stays offered and unchanged
   `SVCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `SVCD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_angle) && $stable(rsp_pulse_us), "response changed while stalled")

   // angle is clamped and the pulse stays in the servo window
   `SVCD_ASSERT(a_angle_range, clock, reset, !rsp_valid || (rsp_angle <= svcd_pkg::AngleMax), "angle above clamp")
   `SVCD_ASSERT(a_pulse_range, clock, reset, !rsp_valid || ((rsp_pulse_us >= svcd_pkg::PulseBase) && (rsp_pulse_us <= svcd_pkg::PulseTop)), "pulse width out of range")

   // a fresh response must follow an accepted line feed request, taken through the request and response registers
   `SVCD_ASSERT(a_rsp_after_lf, clock, reset, !$rose(rsp_valid) || $past(req_valid && req_ready && (req_rx_byte == svcd_pkg::CharLf), 2), "response without line feed")

endmodule

bind servo_command_line_decoder_core svcd_checker u_svcd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_rx_byte  (req_chan.rx_byte),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_angle    (rsp_chan.angle),
   .rsp_pulse_us (rsp_chan.pulse_us)
);
